// ===== hw/rtl/rrf_pkg.sv =====
// Shared widths, limits and register indexes for the rounded rectangle fill rasterizer.
package rrf_pkg;

    localparam int unsigned MAX_DIM  = 4096;
    localparam int unsigned COORD_W  = $clog2(MAX_DIM);
    localparam int unsigned DIM_W    = COORD_W + 1;
    localparam int unsigned RAD_W    = 8;
    localparam int unsigned PITCH_W  = 16;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned COLOR_W  = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR    = 3'd5;

    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [DIM_W-1:0]   t_dim;

    // Clamp a configured size to 1 .. MAX_DIM.
    function automatic t_dim eff_dim(input t_dim v);
        t_dim res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > MAX_DIM_V) begin
            res = MAX_DIM_V;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/rounded_rect_fill_raster.sv =====
// Top level of the rounded rectangle fill rasterizer.
//
// Each request on the slave stream is one raster tick: it yields exactly one
// pixel on the master stream, in raster order over rect_width x rect_height.
// Slave tdata bit 0 is restart: set it to start over at column 0, row 0.
// Master tdata carries the pixel address (base + row*pitch + column, mod 2^32)
// and the fill color; tuser is the write enable, tlast marks the bottom-right
// pixel. After the last pixel the scan wraps and repeats the rectangle.
// Configuration registers are written through the cfg channel, which is always
// ready; write them only while no pixel is in flight.
// An accepted request passes two registers on its way to the master side:
// one input register holding the position, one result register after
// the address multiply-add and the corner distance test. Throughput is one
// pixel per cycle unless the receiver stalls; then the result register holds,
// the input register still takes one more request, and then tready drops.
// Reset clears the valid flags of both stages, the scan counters and all
// configuration registers to their defaults (pitch, width and height 1, others 0).
module rounded_rect_fill_raster (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rrf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rrf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // slave stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,  // [0] restart, [7:1] zero
    // master stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [63:0]                       o_m_axis_tdata,  // [31:0] pixel_address,
                                                               // [63:32] pixel_color
    output logic                              o_m_axis_tuser,  // [0] write_enable
    output logic                              o_m_axis_tlast   // last_pixel
);
    import rrf_pkg::*;

    logic [ADDR_W-1:0]  r_base;
    logic [PITCH_W-1:0] r_pitch;
    logic [RAD_W-1:0]   r_radius;
    t_dim               r_width;
    t_dim               r_height;
    logic [COLOR_W-1:0] r_color;

    t_coord             r_col, r_row;
    t_coord             n_col, n_row;
    t_coord             cur_x, cur_y;

    logic               r_s1_valid;
    t_coord             r_s1_x, r_s1_y;

    logic               r_out_valid;
    logic [ADDR_W-1:0]  r_out_addr;
    logic               r_out_we;
    logic               r_out_last;

    t_dim               w_eff, h_eff;
    logic               accept_in, en_out;
    logic [COORD_W+PITCH_W-1:0] row_off;
    logic [ADDR_W-1:0]  n_addr;
    logic               n_we, n_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_pitch  <= PITCH_W'(1);
            r_radius <= '0;
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_color  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_BASE:    r_base   <= i_cfg_data;
                REG_ROW_PITCH:     r_pitch  <= i_cfg_data[PITCH_W-1:0];
                REG_CORNER_RADIUS: r_radius <= i_cfg_data[RAD_W-1:0];
                REG_RECT_WIDTH:    r_width  <= i_cfg_data[DIM_W-1:0];
                REG_RECT_HEIGHT:   r_height <= i_cfg_data[DIM_W-1:0];
                REG_FILL_COLOR:    r_color  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_eff = eff_dim(r_width);
    assign h_eff = eff_dim(r_height);

    assign en_out          = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || en_out;
    assign accept_in       = i_s_axis_tvalid && o_s_axis_tready;

    assign cur_x = i_s_axis_tdata[0] ? '0 : r_col;
    assign cur_y = i_s_axis_tdata[0] ? '0 : r_row;

    always_comb begin
        n_col = cur_x;
        n_row = cur_y;
        if ((DIM_W'(cur_x) + DIM_W'(1)) >= w_eff) begin
            n_col = '0;
            if ((DIM_W'(cur_y) + DIM_W'(1)) >= h_eff) begin
                n_row = '0;
            end else begin
                n_row = cur_y + COORD_W'(1);
            end
        end else begin
            n_col = cur_x + COORD_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept_in) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (o_s_axis_tready) begin
                r_s1_valid <= accept_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1_x <= cur_x;
            r_s1_y <= cur_y;
        end
    end

    assign row_off = r_s1_y * r_pitch;
    assign n_addr  = r_base + ADDR_W'(row_off) + ADDR_W'(r_s1_x);
    assign n_last  = (DIM_W'(r_s1_x) == (w_eff - DIM_W'(1)))
                  && (DIM_W'(r_s1_y) == (h_eff - DIM_W'(1)));

    rrf_coverage u_coverage (
        .i_x       (r_s1_x),
        .i_y       (r_s1_y),
        .i_w       (w_eff),
        .i_h       (h_eff),
        .i_r       (r_radius),
        .o_covered (n_we)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_s1_valid) begin
            r_out_addr <= n_addr;
            r_out_we   <= n_we;
            r_out_last <= n_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_color, r_out_addr};
    assign o_m_axis_tuser  = r_out_we;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== hw/rtl/rrf_coverage.sv =====
// Coverage test of one pixel position against the rounded rectangle.
module rrf_coverage (
    input  rrf_pkg::t_coord          i_x,
    input  rrf_pkg::t_coord          i_y,
    input  rrf_pkg::t_dim            i_w,
    input  rrf_pkg::t_dim            i_h,
    input  logic [rrf_pkg::RAD_W-1:0] i_r,
    output logic                     o_covered
);
    import rrf_pkg::*;

    localparam int unsigned SW  = DIM_W + 2;
    localparam int unsigned SQW = 2 * SW;
    localparam int unsigned SUW = SQW + 1;

    logic signed [SW-1:0]  sx, sy, sw, sh, sr;
    logic signed [SW-1:0]  xr, yb, wmr, hmr;
    logic signed [SW-1:0]  dxl, dxr, dyt, dyb;
    logic signed [SQW-1:0] sq_xl, sq_xr, sq_yt, sq_yb, sq_r;
    logic signed [SUW-1:0] d_tl, d_tr, d_bl, d_br, rr;
    logic                  left, right, top, bottom, inner;

    assign sx  = signed'(SW'(i_x));
    assign sy  = signed'(SW'(i_y));
    assign sw  = signed'(SW'(i_w));
    assign sh  = signed'(SW'(i_h));
    assign sr  = signed'(SW'(i_r));

    assign wmr = sw - sr;
    assign hmr = sh - sr;
    assign xr  = wmr - SW'(1);
    assign yb  = hmr - SW'(1);

    assign dxl = sx - sr;
    assign dxr = sx - xr;
    assign dyt = sy - sr;
    assign dyb = sy - yb;

    assign sq_xl = dxl * dxl;
    assign sq_xr = dxr * dxr;
    assign sq_yt = dyt * dyt;
    assign sq_yb = dyb * dyb;
    assign sq_r  = sr * sr;

    assign d_tl = SUW'(sq_xl) + SUW'(sq_yt);
    assign d_tr = SUW'(sq_xr) + SUW'(sq_yt);
    assign d_bl = SUW'(sq_xl) + SUW'(sq_yb);
    assign d_br = SUW'(sq_xr) + SUW'(sq_yb);
    assign rr   = SUW'(sq_r);

    assign left   = sx < sr;
    assign right  = sx >= wmr;
    assign top    = sy < sr;
    assign bottom = sy >= hmr;
    assign inner  = ((sx >= sr) && (sx < wmr)) || ((sy >= sr) && (sy < hmr));

    assign o_covered = (i_r == '0) || inner
                    || (left  && top    && (d_tl < rr))
                    || (right && top    && (d_tr < rr))
                    || (left  && bottom && (d_bl < rr))
                    || (right && bottom && (d_br < rr));

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the rounded rectangle fill rasterizer, with scoreboard and drivers.
`timescale 1ns / 1ps

module testbench;
    import rrf_pkg::*;

    localparam int DUT_LATENCY    = 2;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 120;
    localparam int RANDOM_TICKS   = 550;

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic               write_en;
        logic [COLOR_W-1:0] color;
        logic               is_last;
    } t_pixel;

    class pixel_scoreboard;
        logic [ADDR_W-1:0]  frame_base;
        logic [PITCH_W-1:0] row_pitch;
        logic [RAD_W-1:0]   corner_radius;
        logic [DIM_W-1:0]   rect_width;
        logic [DIM_W-1:0]   rect_height;
        logic [COLOR_W-1:0] fill_color;
        logic [COORD_W-1:0] column_count;
        logic [COORD_W-1:0] row_count;
        t_pixel             expected_q[$];
        int                 mismatches;
        int                 checked;
        int                 written;
        int                 masked;
        int                 frame_ends;

        function new();
            frame_base    = '0;
            row_pitch     = PITCH_W'(1);
            corner_radius = '0;
            rect_width    = DIM_W'(1);
            rect_height   = DIM_W'(1);
            fill_color    = '0;
            column_count  = '0;
            row_count     = '0;
            mismatches    = 0;
            checked       = 0;
            written       = 0;
            masked        = 0;
            frame_ends    = 0;
        endfunction

        function longint clamp_size(logic [DIM_W-1:0] v);
            if (v == '0) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return longint'(v);
        endfunction

        function bit disc_hit(longint x, longint y, longint cx, longint cy, longint r);
            longint dx, dy;
            dx = x - cx;
            dy = y - cy;
            return dx * dx + dy * dy < r * r;
        endfunction

        function bit in_fill(longint x, longint y, longint w, longint h, longint r);
            longint xr, yb;
            bit left, right, top, bottom;
            xr     = w - r - 1;
            yb     = h - r - 1;
            left   = x < r;
            right  = x >= w - r;
            top    = y < r;
            bottom = y >= h - r;
            if (r == 0) return 1'b1;
            if ((x >= r && x < w - r) || (y >= r && y < h - r)) return 1'b1;
            if (left && top && disc_hit(x, y, r, r, r)) return 1'b1;
            if (right && top && disc_hit(x, y, xr, r, r)) return 1'b1;
            if (left && bottom && disc_hit(x, y, r, yb, r)) return 1'b1;
            if (right && bottom && disc_hit(x, y, xr, yb, r)) return 1'b1;
            return 1'b0;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FRAME_BASE:    frame_base    = data[ADDR_W-1:0];
                REG_ROW_PITCH:     row_pitch     = data[PITCH_W-1:0];
                REG_CORNER_RADIUS: corner_radius = data[RAD_W-1:0];
                REG_RECT_WIDTH:    rect_width    = data[DIM_W-1:0];
                REG_RECT_HEIGHT:   rect_height   = data[DIM_W-1:0];
                REG_FILL_COLOR:    fill_color    = data[COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_tick(bit restart);
            longint w, h, r, x, y;
            t_pixel px;
            w = clamp_size(rect_width);
            h = clamp_size(rect_height);
            r = longint'(corner_radius);
            if (restart) begin
                column_count = '0;
                row_count    = '0;
            end
            x = longint'(column_count);
            y = longint'(row_count);
            px.address  = frame_base + row_count * row_pitch + column_count;
            px.write_en = in_fill(x, y, w, h, r);
            px.color    = fill_color;
            px.is_last  = (x == w - 1) && (y == h - 1);
            expected_q.push_back(px);
            if (px.write_en) written++;
            else masked++;
            if (px.is_last) frame_ends++;
            if (x + 1 >= w) begin
                column_count = '0;
                if (y + 1 >= h) row_count = '0;
                else row_count = row_count + 1'b1;
            end else begin
                column_count = column_count + 1'b1;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            if (mismatches < 20) $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_pixel(logic [ADDR_W-1:0] address, logic write_en,
                         logic [COLOR_W-1:0] color, logic is_last);
            t_pixel want;
            if (expected_q.size() == 0) begin
                report($sformatf("pixel at address %h with no request pending", address));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (address !== want.address)
                report($sformatf("pixel %0d address %h, want %h", checked, address,
                                 want.address));
            if (write_en !== want.write_en)
                report($sformatf("pixel %0d write enable %b, want %b", checked, write_en,
                                 want.write_en));
            if (color !== want.color)
                report($sformatf("pixel %0d color %h, want %h", checked, color, want.color));
            if (is_last !== want.is_last)
                report($sformatf("pixel %0d last %b, want %b", checked, is_last,
                                 want.is_last));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [63:0]           o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  o_m_axis_tlast;

    pixel_scoreboard sb = new();
    bit burst_mode;
    bit hold_request;
    int holds_done;
    int ticks_sent;
    int setting_count;
    int idle_cycles;

    rounded_rect_fill_raster u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v, int bits);
        logic [CFG_DATA_W-1:0] j;
        j = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom) : '0;
        return v | ((j >> bits) << bits);
    endfunction

    function automatic logic [DIM_W-1:0] pick_size();
        case ($urandom_range(15))
            0:       return '0;
            1:       return DIM_W'(MAX_DIM);
            2:       return DIM_W'($urandom_range(MAX_DIM + 1, (1 << DIM_W) - 1));
            3:       return DIM_W'($urandom_range(13, 300));
            default: return DIM_W'($urandom_range(1, 12));
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.note_config(idx, value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_tick(bit restart);
        int gap;
        gap = burst_mode ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {7'd0, restart};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_tick(restart);
        ticks_sent++;
    endtask

    // drop the request line and wait for every pixel in flight
    task automatic settle();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DUT_LATENCY) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_pixel(o_m_axis_tdata[31:0], o_m_axis_tuser, o_m_axis_tdata[63:32],
                           o_m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : pixel_sink
        int stall_left;
        int run_left;
        i_m_axis_tready = 1'b0;
        stall_left      = 0;
        run_left        = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request    = 1'b0;
                i_m_axis_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                holds_done++;
            end
            if (stall_left == 0 && run_left == 0) begin
                run_left   = ($urandom_range(4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 6);
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                i_m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                i_m_axis_tready = 1'b1;
                run_left--;
            end
        end
    end

    initial begin : stimulus
        int n;
        longint area;
        longint lim;
        bit restart_first;
        idle_cycles     = 0;
        holds_done      = 0;
        ticks_sent      = 0;
        setting_count   = 0;
        burst_mode      = 1'b0;
        hold_request    = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults: a one-pixel rectangle, every pixel ends the frame
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        settle();
        setting_count++;

        // full frame with rounded corners, address wrap and widest pitch
        write_reg(REG_FRAME_BASE, 32'hFFFF_FFF0);
        write_reg(REG_ROW_PITCH, 32'h0000_FFFF);
        write_reg(REG_CORNER_RADIUS, 32'd2);
        write_reg(REG_RECT_WIDTH, 32'd5);
        write_reg(REG_RECT_HEIGHT, 32'd4);
        write_reg(REG_FILL_COLOR, 32'hFFFF_FFFF);
        for (int i = 0; i < 20; i++) send_tick(i == 0);
        settle();
        setting_count++;

        // zero pitch, oversized radius, sizes clamped from both ends
        write_reg(REG_ROW_PITCH, 32'd0);
        write_reg(REG_CORNER_RADIUS, 32'd255);
        write_reg(REG_RECT_WIDTH, 32'd0);
        write_reg(REG_RECT_HEIGHT, 32'h0000_1FFF);
        write_reg(REG_FILL_COLOR, 32'd0);
        send_tick(1'b1);
        send_tick(1'b0);
        setting_count++;

        while (ticks_sent < RANDOM_TICKS + 25) begin
            settle();
            burst_mode = ($urandom_range(3) == 0);
            if ($urandom_range(3) != 0)
                write_reg(REG_RECT_WIDTH, with_junk(CFG_DATA_W'(pick_size()), DIM_W));
            if ($urandom_range(3) != 0)
                write_reg(REG_RECT_HEIGHT, with_junk(CFG_DATA_W'(pick_size()), DIM_W));
            lim = sb.clamp_size(sb.rect_width);
            if (sb.clamp_size(sb.rect_height) < lim) lim = sb.clamp_size(sb.rect_height);
            lim = lim / 2;
            if (lim > 255) lim = 255;
            if ($urandom_range(1)) begin
                case ($urandom_range(5))
                    0:       write_reg(REG_CORNER_RADIUS, with_junk('0, RAD_W));
                    1:       write_reg(REG_CORNER_RADIUS,
                                       with_junk(CFG_DATA_W'($urandom_range(255)), RAD_W));
                    default: write_reg(REG_CORNER_RADIUS,
                                       with_junk(CFG_DATA_W'($urandom_range(0, int'(lim))),
                                                 RAD_W));
                endcase
            end
            if ($urandom_range(1)) begin
                case ($urandom_range(7))
                    0:       write_reg(REG_ROW_PITCH, with_junk('0, PITCH_W));
                    1:       write_reg(REG_ROW_PITCH, with_junk(32'h0000_FFFF, PITCH_W));
                    default: write_reg(REG_ROW_PITCH,
                                       with_junk(CFG_DATA_W'($urandom_range(65535)),
                                                 PITCH_W));
                endcase
            end
            if ($urandom_range(1)) write_reg(REG_FRAME_BASE, $urandom);
            if ($urandom_range(1)) write_reg(REG_FILL_COLOR, $urandom);

            area = sb.clamp_size(sb.rect_width) * sb.clamp_size(sb.rect_height);
            if (area <= 45) n = int'(area) + $urandom_range(0, int'(area));
            else n = $urandom_range(20, 90);
            if (setting_count == 5 || setting_count == 12) begin
                hold_request = 1'b1;
                burst_mode   = 1'b1;
                if (n < 40) n = 40;
            end
            restart_first = ($urandom_range(3) != 0);
            for (int i = 0; i < n; i++)
                send_tick((i == 0 && restart_first) || $urandom_range(39) == 0);
            setting_count++;
        end

        settle();
        repeat (DUT_LATENCY + 4) @(posedge i_clk);
        $display("Checked %0d pixels over %0d register settings: %0d written, %0d masked,",
                 sb.checked, setting_count, sb.written, sb.masked);
        $display("%0d frame ends, %0d long output stalls, %0d mismatches.",
                 sb.frame_ends, holds_done, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
